// File: hdl/lcae_pkg.sv
// Shared types, constants and the cosine table of the LED channel animation engine.
`timescale 1ns / 1ps

package lcae_pkg;

  // Sizing.
  localparam int CHANNELS       = 16;
  localparam int COSINE_ENTRIES = 1024;
  localparam int IDX_W          = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TAB_W          = $clog2(COSINE_ENTRIES);
  localparam int DIV_W          = 32;
  localparam int DEN_W          = 17;
  localparam int DIV_CNT_W      = $clog2(DIV_W + 1);

  // Arithmetic constants.
  localparam logic [31:0]      LCG_TIME_MUL    = 32'd1664525;
  localparam logic [31:0]      LCG_SEED_MUL    = 32'd1013904223;
  localparam logic [15:0]      PERIOD_DEFAULT  = 16'd2000;
  localparam logic [15:0]      PERIOD_FALLBACK = 16'd1000;
  localparam logic [15:0]      PERIOD_MIN      = 16'd10;
  localparam logic [32:0]      HALF_Q16        = 33'd32768;
  localparam logic [31:0]      OFF_BIAS        = 32'd65535;
  localparam logic [16:0]      CENTER_Q16      = 17'd65535;
  localparam logic [15:0]      FULL_Q16        = 16'hFFFF;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_STATIC = 3'd1,
    OP_BREATH = 3'd2,
    OP_CANDLE = 3'd3,
    OP_WARM   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    MODE_STATIC = 2'd0,
    MODE_BREATH = 2'd1,
    MODE_CANDLE = 2'd2,
    MODE_WARM   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    MUL_SQUARE,
    MUL_HASH_T,
    MUL_HASH_S,
    MUL_MAG,
    MUL_BLEND
  } mul_sel_e;

  typedef enum logic {
    DIV_PHASE,
    DIV_INDEX
  } div_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     write;
    logic     ptr_inc;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     acc_en;
    logic     hash_en;
    logic     off_en;
    logic     div_start;
    div_sel_e div_sel;
    logic     rom_rd;
    logic     out_load;
    logic     last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] op;
    logic       ch_ok;
    mode_e      mode;
    logic       ptr_last;
    logic       later_active;
    logic       div_busy;
    logic       out_free;
  } status_t;

  typedef logic [15:0] cos_tab_t [COSINE_ENTRIES];

  // Raised cosine sin^2(pi*k/N) in Q0.16, built with Q2.30 integer steps.
  function automatic cos_tab_t build_cos_table();
    cos_tab_t          tab;
    longint unsigned   y;
    longint unsigned   z;
    longint unsigned   z2;
    longint unsigned   t;
    longint unsigned   sv;
    longint unsigned   sq;
    longint unsigned   s;
    for (int k = 0; k < COSINE_ENTRIES; k++) begin
      y  = (k <= COSINE_ENTRIES - k) ? 64'(k) : 64'(COSINE_ENTRIES - k);
      z  = (y * 64'd3373259426) / 64'(COSINE_ENTRIES);
      z2 = (z * z) >> 30;
      t  = 64'd1073741824 - z2 / 64'd42;
      t  = 64'd1073741824 - (((z2 * t) >> 30) / 64'd20);
      t  = 64'd1073741824 - (((z2 * t) >> 30) / 64'd6);
      sv = (z * t) >> 30;
      sq = (sv * sv) >> 30;
      s  = (sq + 64'd8192) >> 14;
      tab[k] = (s > 64'd65535) ? 16'hFFFF : s[15:0];
    end
    return tab;
  endfunction

  localparam cos_tab_t COS_TABLE = build_cos_table();

endpackage

// File: hdl/lcae_div.sv
// Restoring divider: one quotient bit per cycle, gives quotient and remainder.
`timescale 1ns / 1ps

module lcae_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [lcae_pkg::DIV_W-1:0]        dividend_i,
  input  logic [lcae_pkg::DEN_W-1:0]        divisor_i,
  output logic                              busy_o,
  output logic [lcae_pkg::DIV_W-1:0]        quot_o,
  output logic [lcae_pkg::DEN_W-1:0]        rem_o
);

  logic [lcae_pkg::DIV_W-1:0]     quot_q, quot_d;
  logic [lcae_pkg::DEN_W-1:0]     rem_q, rem_d;
  logic [lcae_pkg::DEN_W-1:0]     den_q;
  logic [lcae_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                           busy_q;
  logic [lcae_pkg::DEN_W:0]       trial;
  logic [lcae_pkg::DEN_W:0]       diff;

  always_comb begin
    trial = {rem_q, quot_q[lcae_pkg::DIV_W-1]};
    diff  = trial - {1'b0, den_q};
    if (trial >= {1'b0, den_q}) begin
      rem_d  = diff[lcae_pkg::DEN_W-1:0];
      quot_d = {quot_q[lcae_pkg::DIV_W-2:0], 1'b1};
    end else begin
      rem_d  = trial[lcae_pkg::DEN_W-1:0];
      quot_d = {quot_q[lcae_pkg::DIV_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= lcae_pkg::DIV_CNT_W'(lcae_pkg::DIV_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - lcae_pkg::DIV_CNT_W'(1);
      if (cnt_q == lcae_pkg::DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      den_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// File: hdl/lcae_dp.sv
// Datapath: channel records, shared multiplier, divider, cosine table and output register.
`timescale 1ns / 1ps

module lcae_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lcae_pkg::cmd_t       cmd_i,
  output lcae_pkg::status_t    status_o,
  input  logic [2:0]           opcode_i,
  input  logic [3:0]           channel_i,
  input  logic [31:0]          time_ms_i,
  input  logic [15:0]          level_a_i,
  input  logic [15:0]          level_b_i,
  input  logic [15:0]          breath_len_i,
  input  logic [31:0]          seed_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [3:0]           channel_out_o,
  output logic [15:0]          duty_o,
  output logic                 last_o
);

  localparam int IDX_W = lcae_pkg::IDX_W;
  localparam int CH    = lcae_pkg::CHANNELS;

  // Captured item.
  logic [2:0]  op_q;
  logic [3:0]  ch_q;
  logic [31:0] time_q;
  logic [15:0] a_in_q, b_in_q, per_in_q;
  logic [31:0] seed_in_q;
  logic [IDX_W-1:0] ptr_q;

  // Channel records.
  lcae_pkg::mode_e mode_q [CH];
  logic [15:0] lva_q [CH];
  logic [15:0] lvb_q [CH];
  logic [15:0] per_q [CH];
  logic [31:0] seed_q [CH];

  logic [31:0] prod_q, acc_q, hash_q;
  logic [15:0] s_q;
  logic [16:0] off_q;

  logic        out_valid_q;
  logic [3:0]  out_ch_q;
  logic [15:0] out_duty_q;
  logic        out_last_q;

  logic [IDX_W+3:0] ch_in_ext;
  logic [IDX_W+3:0] ptr_ext;
  lcae_pkg::mode_e cur_mode;
  logic [15:0] cur_a, cur_b, cur_per;
  logic [31:0] cur_seed;
  logic [lcae_pkg::DEN_W-1:0] per_eff;
  logic [31:0] mul_a, mul_b, prod_d;
  logic [15:0] n16;
  logic        c_neg;
  logic [16:0] c2, mag17;
  logic [31:0] off_num, off_half, off_sum;
  logic [16:0] off_d;
  logic        b_ge;
  logic [15:0] diff;
  logic [32:0] rnd;
  logic [15:0] rnd16;
  logic [16:0] off;
  logic [17:0] sum18;
  logic [15:0] duty;
  logic        later;

  logic                          div_start;
  logic [lcae_pkg::DIV_W-1:0]    div_dividend;
  logic [lcae_pkg::DEN_W-1:0]    div_divisor;
  logic                          div_busy;
  logic [lcae_pkg::DIV_W-1:0]    div_quot;
  logic [lcae_pkg::DEN_W-1:0]    div_rem;

  assign ch_in_ext = {{IDX_W{1'b0}}, channel_i};
  assign ptr_ext   = {4'b0, ptr_q};

  assign cur_mode = mode_q[ptr_q];
  assign cur_a    = lva_q[ptr_q];
  assign cur_b    = lvb_q[ptr_q];
  assign cur_per  = per_q[ptr_q];
  assign cur_seed = seed_q[ptr_q];
  assign per_eff  = (cur_per <= lcae_pkg::PERIOD_MIN) ? {1'b0, lcae_pkg::PERIOD_FALLBACK}
                                                      : {1'b0, cur_per};

  // Candle hash to signed offset magnitude.
  assign n16   = hash_q[23:8];
  assign c_neg = ~n16[15];
  assign c2    = {n16, 1'b0};
  assign mag17 = c_neg ? (lcae_pkg::CENTER_Q16 - c2) : (c2 - lcae_pkg::CENTER_Q16);

  // Candle offset (mag*flicker + 65535) / 131070: halve, then divide by 2^16-1
  // by folding the high half back in. Exact while the quotient stays below 2^16.
  assign off_num  = prod_q + lcae_pkg::OFF_BIAS;
  assign off_half = {1'b0, off_num[31:1]};
  assign off_sum  = off_half + {16'd0, off_half[31:16]} + 32'd1;
  assign off_d    = {1'b0, off_sum[31:16]};

  assign b_ge = (cur_b >= cur_a);
  assign diff = b_ge ? (cur_b - cur_a) : (cur_a - cur_b);

  always_comb begin
    case (cmd_i.mul_sel)
      lcae_pkg::MUL_SQUARE: begin
        mul_a = 32'(cur_a);
        mul_b = 32'(cur_a);
      end
      lcae_pkg::MUL_HASH_T: begin
        mul_a = time_q;
        mul_b = lcae_pkg::LCG_TIME_MUL;
      end
      lcae_pkg::MUL_HASH_S: begin
        mul_a = cur_seed;
        mul_b = lcae_pkg::LCG_SEED_MUL;
      end
      lcae_pkg::MUL_MAG: begin
        mul_a = 32'(mag17[15:0]);
        mul_b = 32'(cur_b);
      end
      default: begin
        mul_a = 32'(diff);
        mul_b = 32'(s_q);
      end
    endcase
    prod_d = mul_a * mul_b;
  end

  always_comb begin
    case (cmd_i.div_sel)
      lcae_pkg::DIV_PHASE: begin
        div_dividend = time_q;
        div_divisor  = per_eff;
      end
      default: begin
        div_dividend = 32'(div_rem[15:0]) * 32'(lcae_pkg::COSINE_ENTRIES);
        div_divisor  = per_eff;
      end
    endcase
  end

  assign div_start = cmd_i.div_start;

  lcae_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Duty selection by the channel's mode.
  always_comb begin
    rnd   = {1'b0, prod_q} + lcae_pkg::HALF_Q16;
    rnd16 = rnd[31:16];
    off   = off_q;
    sum18 = 18'd0;
    duty  = cur_a;
    case (cur_mode)
      lcae_pkg::MODE_STATIC: duty = cur_a;
      lcae_pkg::MODE_WARM:   duty = rnd16;
      lcae_pkg::MODE_BREATH: begin
        if (b_ge) begin
          sum18 = {2'b0, cur_a} + {2'b0, rnd16};
          duty  = (sum18 > 18'(lcae_pkg::FULL_Q16)) ? lcae_pkg::FULL_Q16 : sum18[15:0];
        end else begin
          duty = cur_a - rnd16;
        end
      end
      default: begin
        if (c_neg) begin
          duty = (off > {1'b0, cur_a}) ? 16'd0 : (cur_a - off[15:0]);
        end else begin
          sum18 = {2'b0, cur_a} + {1'b0, off};
          duty  = (sum18 > 18'(lcae_pkg::FULL_Q16)) ? lcae_pkg::FULL_Q16 : sum18[15:0];
        end
      end
    endcase
  end

  always_comb begin
    later = 1'b0;
    for (int i = 0; i < CH; i++) begin
      if ((i > int'(ptr_q)) && (mode_q[i] != lcae_pkg::MODE_STATIC)) begin
        later = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= opcode_i;
      ch_q      <= channel_i;
      time_q    <= time_ms_i;
      a_in_q    <= level_a_i;
      b_in_q    <= level_b_i;
      per_in_q  <= breath_len_i;
      seed_in_q <= seed_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.acc_en) begin
      acc_q <= prod_q;
    end
    if (cmd_i.hash_en) begin
      hash_q <= acc_q + prod_q;
    end
    if (cmd_i.off_en) begin
      off_q <= off_d;
    end
    if (cmd_i.rom_rd) begin
      s_q <= lcae_pkg::COS_TABLE[div_quot[lcae_pkg::TAB_W-1:0]];
    end
    if (cmd_i.out_load) begin
      out_ch_q   <= ptr_ext[3:0];
      out_duty_q <= duty;
      out_last_q <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CH; i++) begin
        mode_q[i] <= lcae_pkg::MODE_STATIC;
        lva_q[i]  <= '0;
        lvb_q[i]  <= '0;
        per_q[i]  <= '0;
        seed_q[i] <= '0;
      end
    end else begin
      if (cmd_i.load) begin
        ptr_q <= (opcode_i == lcae_pkg::OP_TICK) ? '0 : ch_in_ext[IDX_W-1:0];
      end else if (cmd_i.ptr_inc) begin
        ptr_q <= ptr_q + IDX_W'(1);
      end
      if (cmd_i.write) begin
        lva_q[ptr_q] <= a_in_q;
        case (op_q)
          lcae_pkg::OP_STATIC: mode_q[ptr_q] <= lcae_pkg::MODE_STATIC;
          lcae_pkg::OP_BREATH: begin
            mode_q[ptr_q] <= lcae_pkg::MODE_BREATH;
            lvb_q[ptr_q]  <= b_in_q;
            per_q[ptr_q]  <= (per_in_q == 16'd0) ? lcae_pkg::PERIOD_DEFAULT : per_in_q;
          end
          lcae_pkg::OP_CANDLE: begin
            mode_q[ptr_q] <= lcae_pkg::MODE_CANDLE;
            lvb_q[ptr_q]  <= b_in_q;
            seed_q[ptr_q] <= seed_in_q;
          end
          default: mode_q[ptr_q] <= lcae_pkg::MODE_WARM;
        endcase
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.op           = op_q;
  assign status_o.ch_ok        = (32'(ch_q) < 32'(CH));
  assign status_o.mode         = cur_mode;
  assign status_o.ptr_last     = (32'(ptr_q) == 32'(CH - 1));
  assign status_o.later_active = later;
  assign status_o.div_busy     = div_busy;
  assign status_o.out_free     = ~out_valid_q | ~out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign channel_out_o = out_ch_q;
  assign duty_o        = out_duty_q;
  assign last_o        = out_last_q;

endmodule

// File: hdl/lcae_ctrl.sv
// Controller state machine that sequences set items and the per-channel tick walk.
`timescale 1ns / 1ps

module lcae_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lcae_pkg::status_t status_i,
  output lcae_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WRITE,
    ST_SCAN,
    ST_SQUARE,
    ST_MOD_WAIT,
    ST_IDX_WAIT,
    ST_BLEND,
    ST_HASH_T,
    ST_HASH_S,
    ST_HASH_SUM,
    ST_MAG,
    ST_OFFSET,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   is_tick;

  assign is_tick = (status_i.op == lcae_pkg::OP_TICK);

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.mul_sel = lcae_pkg::MUL_SQUARE;
    cmd_o.div_sel = lcae_pkg::DIV_PHASE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (is_tick) begin
          state_d = ST_SCAN;
        end else if (status_i.ch_ok && (status_i.op inside {lcae_pkg::OP_STATIC,
                     lcae_pkg::OP_BREATH, lcae_pkg::OP_CANDLE, lcae_pkg::OP_WARM})) begin
          state_d = ST_WRITE;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_WRITE: begin
        cmd_o.write = 1'b1;
        case (status_i.op)
          lcae_pkg::OP_STATIC: state_d = ST_EMIT;
          lcae_pkg::OP_WARM:   state_d = ST_SQUARE;
          default:             state_d = ST_IDLE;
        endcase
      end
      ST_SCAN: begin
        case (status_i.mode)
          lcae_pkg::MODE_BREATH: begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_sel   = lcae_pkg::DIV_PHASE;
            state_d         = ST_MOD_WAIT;
          end
          lcae_pkg::MODE_CANDLE: state_d = ST_HASH_T;
          lcae_pkg::MODE_WARM:   state_d = ST_SQUARE;
          default: begin
            if (status_i.ptr_last) begin
              state_d = ST_IDLE;
            end else begin
              cmd_o.ptr_inc = 1'b1;
            end
          end
        endcase
      end
      ST_SQUARE: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = lcae_pkg::MUL_SQUARE;
        state_d       = ST_EMIT;
      end
      ST_MOD_WAIT: begin
        if (!status_i.div_busy) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = lcae_pkg::DIV_INDEX;
          state_d         = ST_IDX_WAIT;
        end
      end
      ST_IDX_WAIT: begin
        if (!status_i.div_busy) begin
          cmd_o.rom_rd = 1'b1;
          state_d      = ST_BLEND;
        end
      end
      ST_BLEND: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = lcae_pkg::MUL_BLEND;
        state_d       = ST_EMIT;
      end
      ST_HASH_T: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = lcae_pkg::MUL_HASH_T;
        state_d       = ST_HASH_S;
      end
      ST_HASH_S: begin
        cmd_o.acc_en  = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = lcae_pkg::MUL_HASH_S;
        state_d       = ST_HASH_SUM;
      end
      ST_HASH_SUM: begin
        cmd_o.hash_en = 1'b1;
        state_d       = ST_MAG;
      end
      ST_MAG: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = lcae_pkg::MUL_MAG;
        state_d       = ST_OFFSET;
      end
      ST_OFFSET: begin
        cmd_o.off_en = 1'b1;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.last     = ~is_tick | ~status_i.later_active;
          if (is_tick && !status_i.ptr_last) begin
            cmd_o.ptr_inc = 1'b1;
            state_d       = ST_SCAN;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

// File: hdl/led_channel_animation_engine_top.sv
// Top level of the LED channel animation engine: controller plus datapath.
`timescale 1ns / 1ps

//  Channel | Handshake                | Beat payload
//  --------+--------------------------+---------------------------------------------------
//  in      | in_valid_i / in_stall_o  | opcode, channel, time_ms, level_a, level_b,
//          |                          | breath_len, seed
//  out     | out_valid_o / out_stall_i| channel_out, duty, last
//
// One input beat is worked on at a time. A tick walks the channels, and the shared
// 32-step restoring divider runs twice per breath channel (phase, then index).
// Reset clears all channel records to static with zero levels, period and seed.
// A stalled output beat holds in the output register, and the next beat waits for it.

module led_channel_animation_engine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  opcode_i,
  input  logic [3:0]  channel_i,
  input  logic [31:0] time_ms_i,
  input  logic [15:0] level_a_i,
  input  logic [15:0] level_b_i,
  input  logic [15:0] breath_len_i,
  input  logic [31:0] seed_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  channel_out_o,
  output logic [15:0] duty_o,
  output logic        last_o
);

  lcae_pkg::cmd_t    cmd;
  lcae_pkg::status_t status;

  // The controller loads a beat only from idle, so valid alone starts it.
  lcae_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lcae_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .opcode_i      (opcode_i),
    .channel_i     (channel_i),
    .time_ms_i     (time_ms_i),
    .level_a_i     (level_a_i),
    .level_b_i     (level_b_i),
    .breath_len_i  (breath_len_i),
    .seed_i        (seed_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .channel_out_o (channel_out_o),
    .duty_o        (duty_o),
    .last_o        (last_o)
  );

endmodule
